@@ sv/afi_pkg.sv @@
// ---------------------------------------------------------------------------
// afi_pkg: shared constants for the affine matrix inverse block
// Lane count, widths of the determinant and quotient, and queue depth.
// ---------------------------------------------------------------------------
package afi_pkg;

  localparam int LANES      = 6;   // six quotients per matrix
  localparam int DEN_W      = 64;  // determinant magnitude width
  localparam int Q_W        = 32;  // quotient width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [Q_W-1:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;

endpackage

@@ sv/affine_2x3_matrix_invert.sv @@
// ---------------------------------------------------------------------------
// affine_2x3_matrix_invert: inverse of a 2D affine matrix per transfer
// Streams signed fixed-point matrices in and their inverses out, truncated toward zero.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one matrix per transfer: a, b, c, d, tx, ty,
//   each 32-bit signed with FRAC_BITS fraction bits. The master channel
//   returns one transfer per matrix, in order, with the six inverse entries
//   in tdata and the invertible and overflow flags in tuser.
//   The transfer edge loads the input register; the product register, one
//   queue slot, the entry stage, 32 quotient stages (one bit of all six
//   quotients per stage) and the output register follow.
//   Throughput is one matrix per cycle while the receiver does not stall;
//   the rate is set by the 32-stage quotient pipeline, which holds one
//   matrix in each stage.
//   A four-entry queue separates the multiplier front from the divider back,
//   so the front keeps taking matrices while the back is held.
//   When the receiver stalls, the back pipeline and output register hold
//   their contents; once the queue and product register fill, s_tready drops.
//   A singular matrix gives zero entries with both flags low; a quotient
//   out of the 32-bit range saturates and sets overflow.
//   Synchronous reset empties the pipelines and queue; no item is kept.
// ---------------------------------------------------------------------------
module affine_2x3_matrix_invert
  import afi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // lin_a, lin_b, lin_c, lin_d, shift_x, shift_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // inv_lin_a, inv_lin_b, inv_lin_c, inv_lin_d,
                                  // inv_shift_x, inv_shift_y
  output logic [1:0]   m_tuser    // invertible, overflow
);

  // Widest numerator is a translation magnitude shifted by FRAC_BITS.
  localparam int NUM_W   = 64 + FRAC_BITS;
  localparam int ENTRY_W = LANES * NUM_W + LANES + DEN_W + 1;

  logic               f_valid, f_ready;
  logic [ENTRY_W-1:0] f_data;
  logic               b_valid, b_ready;
  logic [ENTRY_W-1:0] b_data;

  afi_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W), .ENTRY_W(ENTRY_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  afi_fifo #(.W(ENTRY_W)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  afi_back #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W), .ENTRY_W(ENTRY_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ sv/afi_front.sv @@
// ---------------------------------------------------------------------------
// afi_front: input stage, products and classification
// Registers the matrix, forms the six exact products, then the determinant
// and translation numerators as sign and magnitude, ready for division.
// ---------------------------------------------------------------------------
module afi_front
  import afi_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W     = 64 + FRAC_BITS,
  parameter int ENTRY_W   = LANES * NUM_W + LANES + DEN_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [191:0]       s_tdata,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [ENTRY_W-1:0] push_data
);

  logic v1, v2, fen;
  logic signed [31:0] a1, b1, c1, d1, tx1, ty1;
  logic signed [31:0] a2, b2, c2, d2;
  logic signed [63:0] p_ad, p_bc, p_cty, p_dtx, p_btx, p_aty;

  logic [DEN_W-1:0]             det_mag, tnx_mag, tny_mag;
  logic                         det_neg, tnx_neg, tny_neg;
  logic [LANES-1:0][NUM_W-1:0]  num;
  logic [LANES-1:0]             rneg;

  function automatic logic [DEN_W:0] diff_prod(input logic signed [63:0] p1,
                                               input logic signed [63:0] p2);
    logic ge;
    logic [DEN_W-1:0] m;
    begin
      ge = (p1 >= p2);
      m  = ge ? (DEN_W'(p1) - DEN_W'(p2)) : (DEN_W'(p2) - DEN_W'(p1));
      return {~ge, m};
    end
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (32'd0 - 32'(x)) : 32'(x);
  endfunction

  assign fen        = !v2 || push_ready;
  assign s_tready   = fen;
  assign push_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (fen) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      a1  <= s_tdata[31:0];
      b1  <= s_tdata[63:32];
      c1  <= s_tdata[95:64];
      d1  <= s_tdata[127:96];
      tx1 <= s_tdata[159:128];
      ty1 <= s_tdata[191:160];
      a2  <= a1;
      b2  <= b1;
      c2  <= c1;
      d2  <= d1;
      p_ad  <= a1 * d1;
      p_bc  <= b1 * c1;
      p_cty <= c1 * ty1;
      p_dtx <= d1 * tx1;
      p_btx <= b1 * tx1;
      p_aty <= a1 * ty1;
    end
  end

  always_comb begin
    {det_neg, det_mag} = diff_prod(p_ad, p_bc);
    {tnx_neg, tnx_mag} = diff_prod(p_cty, p_dtx);
    {tny_neg, tny_mag} = diff_prod(p_btx, p_aty);
    num[0]  = NUM_W'(mag32(d2)) << (2 * FRAC_BITS);
    num[1]  = NUM_W'(mag32(b2)) << (2 * FRAC_BITS);
    num[2]  = NUM_W'(mag32(c2)) << (2 * FRAC_BITS);
    num[3]  = NUM_W'(mag32(a2)) << (2 * FRAC_BITS);
    num[4]  = NUM_W'(tnx_mag) << FRAC_BITS;
    num[5]  = NUM_W'(tny_mag) << FRAC_BITS;
    // Result sign is the numerator sign against the determinant sign;
    // the off-diagonal entries carry a negation.
    rneg[0] = d2[31] ^ det_neg;
    rneg[1] = (!b2[31] && (b2 != '0)) ^ det_neg;
    rneg[2] = (!c2[31] && (c2 != '0)) ^ det_neg;
    rneg[3] = a2[31] ^ det_neg;
    rneg[4] = tnx_neg ^ det_neg;
    rneg[5] = tny_neg ^ det_neg;
  end

  assign push_data = {(det_mag != '0), det_mag, rneg, num};

endmodule

@@ sv/afi_fifo.sv @@
// ---------------------------------------------------------------------------
// afi_fifo: short queue between the front and back parts
// Four entries of registers with the head visible for a direct pop.
// ---------------------------------------------------------------------------
module afi_fifo
  import afi_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     count;
  logic                 push, pop;

  assign push_ready = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

@@ sv/afi_back.sv @@
// ---------------------------------------------------------------------------
// afi_back: pipelined division and saturation
// Six restoring dividers, one quotient bit per stage, then saturation into
// the output register.
// ---------------------------------------------------------------------------
module afi_back
  import afi_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W     = 64 + FRAC_BITS,
  parameter int ENTRY_W   = LANES * NUM_W + LANES + DEN_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [191:0]       m_tdata,
  output logic [1:0]         m_tuser
);

  logic ben;
  logic [LANES-1:0][NUM_W-1:0] in_num;
  logic [LANES-1:0]            in_neg;
  logic [DEN_W-1:0]            in_den;
  logic                        in_nz;

  logic                        v   [Q_W+1];
  logic [DEN_W-1:0]            den [Q_W+1];
  logic                        nz  [Q_W+1];
  logic [LANES-1:0]            neg [Q_W+1];
  logic [LANES-1:0]            big [Q_W+1];
  logic [LANES-1:0][DEN_W-1:0] r   [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   w   [Q_W+1];

  logic [LANES-1:0][Q_W-1:0]   res;
  logic [LANES-1:0]            sat;

  function automatic logic [DEN_W+Q_W-1:0] div_step(input logic [DEN_W-1:0] rin,
                                                   input logic [Q_W-1:0] win,
                                                   input logic [DEN_W-1:0] dv);
    logic [DEN_W:0] r2;
    logic           qb;
    begin
      r2 = {rin, win[Q_W-1]};
      qb = (r2 >= {1'b0, dv});
      if (qb) r2 = r2 - {1'b0, dv};
      return {r2[DEN_W-1:0], win[Q_W-2:0], qb};
    end
  endfunction

  assign {in_nz, in_den, in_neg, in_num} = pop_data;
  assign ben       = !m_tvalid || m_tready;
  assign pop_ready = ben;

  // Entry stage: overflow check on the high part and remainder seed.
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (ben) v[0] <= pop_valid;
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      den[0] <= in_den;
      nz[0]  <= in_nz;
      neg[0] <= in_neg;
      for (int l = 0; l < LANES; l++) begin
        big[0][l] <= (DEN_W'(in_num[l][NUM_W-1:Q_W]) >= in_den);
        r[0][l]   <= DEN_W'(in_num[l][NUM_W-1:Q_W]);
        w[0][l]   <= in_num[l][Q_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else if (ben) v[k+1] <= v[k];
    end

    always_ff @(posedge clk) begin
      if (ben) begin
        den[k+1] <= den[k];
        nz[k+1]  <= nz[k];
        neg[k+1] <= neg[k];
        big[k+1] <= big[k];
        for (int l = 0; l < LANES; l++) begin
          {r[k+1][l], w[k+1][l]} <= div_step(r[k][l], w[k][l], den[k]);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [Q_W-1:0] lim, q;
      lim    = neg[Q_W][l] ? NEG_LIMIT : POS_LIMIT;
      sat[l] = big[Q_W][l] || (w[Q_W][l] > lim);
      q      = sat[l] ? lim : w[Q_W][l];
      res[l] = neg[Q_W][l] ? (Q_W'(0) - q) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (ben) m_tvalid <= v[Q_W];
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      m_tdata <= nz[Q_W] ? res : '0;
      m_tuser <= {nz[Q_W] && (sat != '0), nz[Q_W]};
    end
  end

endmodule

@@ sv/afi_checker.sv @@
// ---------------------------------------------------------------------------
// afi_checker: port-level checks for the affine matrix inverse
// Output hold under stall, empty output after reset, singular and overflow flag consistency.
// ---------------------------------------------------------------------------
module afi_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [191:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata,
  input logic [1:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_singular: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("singular result not zero");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |->
      m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
      m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
      m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000 ||
      m_tdata[127:96] == 32'h7fffffff || m_tdata[127:96] == 32'h80000000 ||
      m_tdata[159:128] == 32'h7fffffff || m_tdata[159:128] == 32'h80000000 ||
      m_tdata[191:160] == 32'h7fffffff || m_tdata[191:160] == 32'h80000000)
    else $error("overflow set without a saturated entry");

endmodule

bind affine_2x3_matrix_invert afi_checker u_afi_checker (.*);

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: stream check of the affine 2x3 matrix inverse
// Drives matrices into the slave channel with random gaps, predicts each
// inverse with exact long division, and compares every output transfer.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import afi_pkg::*;

  localparam int FB        = 16;
  localparam int N_RANDOM  = 800;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 60;

  typedef struct packed {
    logic [31:0] sy, sx, d, c, b, a;
  } matrix_t;

  typedef struct {
    logic [31:0] e[6];
    logic        inv;
    logic        ovf;
  } inverse_t;

  // Scoreboard: computes the expected inverse of each accepted matrix and
  // checks output transfers against the oldest pending one.
  class inverse_board;
    inverse_t pending[$];
    int errors;
    int checked;
    int singular_seen;
    int ovf_seen;

    // Signed quotient (num_neg, num_mag << sh) / (den_neg, den_mag),
    // truncated toward zero and saturated to 32 bits.
    function logic [31:0] sat_quot(bit num_neg, logic [127:0] num_mag,
                                   int sh, bit den_neg,
                                   logic [127:0] den_mag,
                                   ref bit ovf);
      logic [127:0] q;
      logic [127:0] lim;
      bit neg;
      neg = num_neg != den_neg;
      q   = (num_mag << sh) / den_mag;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
        q   = lim;
        ovf = 1;
      end
      if (neg) q = -q;
      return q[31:0];
    endfunction

    function void note_matrix(matrix_t m);
      inverse_t r;
      logic signed [64:0] det, tnx, tny;
      logic signed [31:0] a, b, c, d, tx, ty;
      logic [127:0] dm;
      bit dn, ovf;
      a = m.a; b = m.b; c = m.c; d = m.d; tx = m.sx; ty = m.sy;
      det = 65'(a) * 65'(d) - 65'(b) * 65'(c);
      tnx = 65'(c) * 65'(ty) - 65'(d) * 65'(tx);
      tny = 65'(b) * 65'(tx) - 65'(a) * 65'(ty);
      ovf = 0;
      if (det == 0) begin
        foreach (r.e[k]) r.e[k] = '0;
        r.inv = 0;
        r.ovf = 0;
      end else begin
        dn = det < 0;
        dm = 128'(dn ? -det : det);
        r.e[0] = sat_quot(d < 0, 128'(d < 0 ? -64'(d) : 64'(d)), 2*FB, dn, dm, ovf);
        r.e[1] = sat_quot(b > 0, 128'(b < 0 ? -64'(b) : 64'(b)), 2*FB, dn, dm, ovf);
        r.e[2] = sat_quot(c > 0, 128'(c < 0 ? -64'(c) : 64'(c)), 2*FB, dn, dm, ovf);
        r.e[3] = sat_quot(a < 0, 128'(a < 0 ? -64'(a) : 64'(a)), 2*FB, dn, dm, ovf);
        r.e[4] = sat_quot(tnx < 0, 128'(tnx < 0 ? -tnx : tnx), FB, dn, dm, ovf);
        r.e[5] = sat_quot(tny < 0, 128'(tny < 0 ? -tny : tny), FB, dn, dm, ovf);
        r.inv = 1;
        r.ovf = ovf;
      end
      if (!r.inv) singular_seen++;
      if (r.ovf) ovf_seen++;
      pending.push_back(r);
    endfunction

    function void check_inverse(logic [191:0] data, logic [1:0] user);
      inverse_t x;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: output transfer with nothing expected");
        return;
      end
      x = pending.pop_front();
      checked++;
      bad = 0;
      for (int k = 0; k < 6; k++)
        if (data[32*k +: 32] !== x.e[k]) bad = 1;
      if (user[0] !== x.inv || user[1] !== x.ovf) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d expected %h %h %h %h %h %h inv=%b ovf=%b, got %h tuser=%b",
                   checked, x.e[0], x.e[1], x.e[2], x.e[3], x.e[4], x.e[5],
                   x.inv, x.ovf, data, user);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [191:0] m_tdata;
  logic [1:0]   m_tuser;

  inverse_board board = new();
  int  idle_cycles = 0;
  int  n_sent = 0;

  affine_2x3_matrix_invert #(.FRAC_BITS(FB)) uut (.*);

  initial forever #5 clk = ~clk;

  // Gap length: mostly zero or short, now and then a long stretch.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one matrix and hold it until the block accepts the transfer.
  // Valid drops only when a gap follows, so back-to-back transfers keep it high.
  task automatic send_matrix(matrix_t m);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= m;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_matrix(m);
    n_sent++;
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 131072)) - 65536);
      3: return 32'(signed'($urandom_range(0, 2048)) - 1024);
      4: return 32'h0001_0000;
      5: return 32'(signed'($urandom_range(0, 2 << 20)) - (1 << 20));
      default: return $urandom();
    endcase
  endfunction

  // Output side: random stalls, then check each accepted transfer.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        m_tready <= 0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.check_inverse(m_tdata, m_tuser);
    end
  end

  // Watchdog: counts cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("affine_2x3_matrix_invert test failed");
      $finish;
    end
  end

  initial begin
    matrix_t m;
    logic [31:0] edge_vals[6];
    edge_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  32'h0001_0000};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: identity, singular, tiny determinant, extremes.
    send_matrix('{sy: 0, sx: 0, d: 32'h10000, c: 0, b: 0, a: 32'h10000});
    send_matrix('{sy: 32'h30000, sx: 32'hfffe0000, d: 32'h20000, c: 32'h10000,
                  b: 32'hffff0000, a: 32'h40000});
    send_matrix('{default: 32'h0});
    send_matrix('{sy: 5, sx: 7, d: 32'h20000, c: 32'h10000, b: 32'h20000,
                  a: 32'h10000});
    send_matrix('{sy: 32'h7fff_ffff, sx: 32'h8000_0000, d: 1, c: 0, b: 0, a: 1});
    send_matrix('{sy: 32'h8000_0000, sx: 32'h7fff_ffff, d: 32'hffff_ffff, c: 0,
                  b: 0, a: 32'hffff_ffff});
    send_matrix('{sy: 32'hffff_ffff, sx: 32'hffff_ffff, d: 32'h8000_0000,
                  c: 32'h8000_0000, b: 32'h8000_0000, a: 32'h8000_0000});
    send_matrix('{sy: 1, sx: 1, d: 32'h7fff_ffff, c: 32'h8000_0000,
                  b: 32'h7fff_ffff, a: 32'h8000_0000});
    send_matrix('{sy: 32'h10000, sx: 32'h10000, d: 32'h7fff_ffff, c: 0, b: 0,
                  a: 32'h7fff_ffff});
    send_matrix('{sy: 32'hffff_ffff, sx: 32'h0, d: 0, c: 32'h10000,
                  b: 32'hffff0000, a: 0});
    for (int k = 0; k < 12; k++) begin
      m.a = edge_vals[$urandom_range(0, 5)]; m.b = edge_vals[$urandom_range(0, 5)];
      m.c = edge_vals[$urandom_range(0, 5)]; m.d = edge_vals[$urandom_range(0, 5)];
      m.sx = edge_vals[$urandom_range(0, 5)]; m.sy = edge_vals[$urandom_range(0, 5)];
      send_matrix(m);
    end

    // Random part: some singular matrices built from proportional rows.
    for (int k = 0; k < N_RANDOM; k++) begin
      m.a = rand_entry(); m.b = rand_entry(); m.c = rand_entry(); m.d = rand_entry();
      m.sx = rand_entry(); m.sy = rand_entry();
      if ($urandom_range(0, 9) == 0) begin
        m.c = m.a; m.d = m.b;
      end
      send_matrix(m);
    end
    s_tvalid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
             n_sent, board.checked, board.singular_seen, board.ovf_seen);
    if (board.errors == 0) begin
      $display("affine_2x3_matrix_invert test passed");
    end else begin
      $display("%0d mismatches in total", board.errors);
      $display("affine_2x3_matrix_invert test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/afi_pkg.sv
sv/afi_front.sv
sv/afi_fifo.sv
sv/afi_back.sv
sv/affine_2x3_matrix_invert.sv
sv/afi_checker.sv
tb/testbench.sv
